### rtl/btw_pkg.sv
`timescale 1ns / 1ps

package btw_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WIDTH_W   = 11;
    localparam int THRESH_W  = 8;
    localparam int PIXEL_W   = 8;
    localparam int MIN_WIDTH = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(128);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]    ROW_MAX      = '1;

    // register select, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WIDTH     = 1'b1;

    // line store word: upper row bit above middle row bit
    localparam int LINE_W = 2;

    typedef struct packed {
        logic [PIXEL_W-1:0] gray_pixel;
        logic               frame_start;
    } pixel_t;

    typedef struct packed {
        logic centre_valid;
        logic thin_mark;
    } mark_t;

    // window bit 3*row+col, row 0 on top, col 0 on the left
    function automatic logic window_test(input logic [8:0] w);
        logic [7:0] ring;
        logic       ctr;
        logic [3:0] steps;
        logic [3:0] same;
        begin
            ctr   = w[4];
            ring  = {w[3], w[6], w[7], w[8], w[5], w[2], w[1], w[0]};
            steps = '0;
            same  = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (ring[i] && !ring[(i + 1) % 8])
                begin
                    steps = steps + 4'd1;
                end
                if (ring[i] == ctr)
                begin
                    same = same + 4'd1;
                end
            end
            window_test = (steps == 4'd1) && (same >= 4'd3) && (same <= 4'd7) &&
                          ((ring[1] != ctr) || (ring[3] != ctr) ||
                           ((ring[7] != ctr) && (ring[5] != ctr)));
        end
    endfunction

endpackage

### rtl/binary_thinning_window_test.sv
`timescale 1ns / 1ps

// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------
// pixel in  | pixel_valid / pixel_ready  | pixel  (gray_pixel, frame_start)
// mark out  | mark_valid / mark_ready    | mark   (centre_valid, thin_mark)
// config    | psel / penable / pready    | paddr, pwrite, pwdata, prdata
//
// One transaction per cycle unless the mark stalls; a pixel goes to stage 1, then to mark.
// Line store read is issued on accept, window test runs on the registered read.
// After reset the line store is cleared word by word; pixel_ready stays low.
// A stalled mark holds both pipeline stages; config is accepted at any time.

module binary_thinning_window_test
    import btw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  pixel_t             pixel,
    output logic               mark_valid,
    input  logic               mark_ready,
    output mark_t              mark,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [THRESH_W-1:0] thresh_reg;
    logic [WIDTH_W-1:0]  width_reg;

    logic                clearing_reg, clearing_next;
    logic [COL_W-1:0]    clr_addr_reg, clr_addr_next;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic                s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_cur_reg;
    logic                s1_row1_reg;
    logic                s1_row2_reg;
    logic                byp_hit_reg;
    logic [LINE_W-1:0]   byp_data_reg;

    logic [8:0]          window_reg, window_next;
    logic                mark_valid_reg, mark_valid_next;
    mark_t               mark_reg, mark_next;

    logic                accept;
    logic                s1_adv;
    logic [WIDTH_W-1:0]  eff_width;
    logic [COL_W-1:0]    col_in;
    logic [ROW_W-1:0]    row_in;
    logic                col_wrap;
    logic                cur_in;

    logic                ram_we;
    logic [COL_W-1:0]    ram_waddr;
    logic [LINE_W-1:0]   ram_wdata;
    logic [LINE_W-1:0]   ram_rdata;
    logic [LINE_W-1:0]   s1_rd;
    logic                up_bit;
    logic                mid_bit;
    logic                centre_ok;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            width_reg  <= WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_THRESHOLD: thresh_reg <= pwdata[THRESH_W-1:0];
                REG_WIDTH:     width_reg  <= pwdata[WIDTH_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = {{(PDATA_W-THRESH_W){1'b0}}, thresh_reg};
            REG_WIDTH:     prdata = {{(PDATA_W-WIDTH_W){1'b0}}, width_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        if (width_reg < WIDTH_W'(MIN_WIDTH))
        begin
            eff_width = WIDTH_W'(MIN_WIDTH);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    // handshakes
    assign s1_adv      = s1_valid_reg && (!mark_valid_reg || mark_ready);
    assign pixel_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept      = pixel_valid && pixel_ready;

    // stage 0: position tracking and line store read
    assign col_in   = pixel.frame_start ? '0 : col_reg;
    assign row_in   = pixel.frame_start ? '0 : row_reg;
    assign col_wrap = ({1'b0, col_in} + WIDTH_W'(1)) >= eff_width;
    assign cur_in   = pixel.gray_pixel > thresh_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            row_next = row_in;
            if (col_wrap)
            begin
                col_next = '0;
                if (row_in != ROW_MAX)
                begin
                    row_next = row_in + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_in + COL_W'(1);
            end
        end
    end

    // clearing pass after reset
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    assign ram_we    = clearing_reg || s1_adv;
    assign ram_waddr = clearing_reg ? clr_addr_reg : s1_col_reg;
    assign ram_wdata = clearing_reg ? '0 : {mid_bit, s1_cur_reg};

    btw_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_in),
        .rdata (ram_rdata)
    );

    // stage 1: window update and test
    assign s1_rd   = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign up_bit  = s1_rd[1];
    assign mid_bit = s1_rd[0];

    always_comb
    begin
        window_next = ({1'b0, window_reg[8:1]} & 9'h0DB) |
                      {6'b0, up_bit, 2'b0} | {3'b0, mid_bit, 5'b0} |
                      {s1_cur_reg, 8'b0};
        centre_ok   = s1_row1_reg && (s1_col_reg != '0);
        mark_next.centre_valid = centre_ok;
        mark_next.thin_mark    = centre_ok && s1_row2_reg && (s1_col_reg >= COL_W'(2)) &&
                                 window_test(window_next);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        mark_valid_next = mark_valid_reg;
        if (s1_adv)
        begin
            mark_valid_next = 1'b1;
        end
        else if (mark_ready)
        begin
            mark_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            mark_valid_reg <= 1'b0;
            window_reg     <= '0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clr_addr_reg   <= clr_addr_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= s1_valid_next;
            mark_valid_reg <= mark_valid_next;
            if (s1_adv)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_in;
            s1_cur_reg   <= cur_in;
            s1_row1_reg  <= row_in != '0;
            s1_row2_reg  <= row_in >= ROW_W'(2);
            // same-cycle write to the address being read
            byp_hit_reg  <= ram_we && (ram_waddr == col_in);
            byp_data_reg <= ram_wdata;
        end
        if (s1_adv)
        begin
            mark_reg <= mark_next;
        end
    end

    assign mark_valid = mark_valid_reg;
    assign mark       = mark_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pixel_ready)
        else $error("pixel accepted during line store clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid_reg |-> (mark_reg.centre_valid || !mark_reg.thin_mark))
        else $error("mark set without a valid centre");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stage 1 lost a stalled transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && byp_hit_reg) |-> (s1_col_reg == '0))
        else $error("line store bypass at a column other than zero");

endmodule

### rtl/btw_ram.sv
`timescale 1ns / 1ps

module btw_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
